### rtl/sssnz_pkg.sv
`timescale 1ns / 1ps
package sssnz_pkg;

   localparam int MAX_ITEMS_DEF  = 16;
   localparam int VALUE_BITS_DEF = 8;

   localparam int WORD_BITS   = 64;
   localparam int WORD_SHIFT  = 6;
   localparam int MASK_OUT_W  = 16;
   localparam int SUM_OUT_W   = 12;
   localparam int COUNT_OUT_W = 5;

   localparam int HALF_SPAN_DEF = MAX_ITEMS_DEF << (VALUE_BITS_DEF - 1);
   localparam int SPAN_DEF      = 2 * HALF_SPAN_DEF + 1;
   localparam int WORDS_DEF     = (SPAN_DEF + WORD_BITS - 1) / WORD_BITS;
   localparam int RAM_DEPTH_DEF = MAX_ITEMS_DEF * WORDS_DEF;
   localparam int RAM_AW_DEF    = $clog2(RAM_DEPTH_DEF);

endpackage

### rtl/sssnz_ram.sv
`timescale 1ns / 1ps
module sssnz_ram
   import sssnz_pkg::*;
#(
   parameter int DEPTH  = RAM_DEPTH_DEF,
   parameter int ADDR_W = RAM_AW_DEF
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]    rd0_addr,
   input  logic [ADDR_W-1:0]    rd1_addr,
   output logic [WORD_BITS-1:0] rd0_data,
   output logic [WORD_BITS-1:0] rd1_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_data <= mem[rd0_addr];
      rd1_data <= mem[rd1_addr];
   end

endmodule

### rtl/signed_subset_sum_nearest_zero.sv
`timescale 1ns / 1ps
// Load beats are accepted while idle; a beat with last starts the search.
// Table build: n rows (BROW, BSWEEP, BDRAIN), WORDS = 65 at default size (64-bit shift-or sweep).
// Nearest search: SISSUE then SCHECK per distance tried; trace-back: TTEST then TCHECK per row; then DONE loads result.
// One set at a time; req_ready is low from the closing beat until the result register loads.
// Synchronous active-high reset clears count, flags, sequencer and rsp_valid; table needs no clear.
module signed_subset_sum_nearest_zero
   import sssnz_pkg::*;
#(
   parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [MASK_OUT_W-1:0]        rsp_subset_mask,
   output logic signed [SUM_OUT_W-1:0]  rsp_subset_sum,
   output logic                         rsp_exact_zero,
   output logic [COUNT_OUT_W-1:0]       rsp_element_count,
   output logic                         rsp_overflowed
);

   localparam int HALF_SPAN = MAX_ITEMS << (VALUE_BITS - 1);
   localparam int SPAN      = 2 * HALF_SPAN + 1;
   localparam int WORDS     = (SPAN + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH     = MAX_ITEMS * WORDS;
   localparam int AW        = $clog2(DEPTH);
   localparam int IW        = $clog2(SPAN);
   localparam int SW        = IW + 8;
   localparam int CW        = $clog2(MAX_ITEMS + 1);
   localparam int RW        = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int KW        = $clog2(WORDS + 1);
   localparam int PW        = 1 + AW + WORD_SHIFT;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BROW, ST_BSWEEP, ST_BDRAIN, ST_XISSUE, ST_XCHECK,
      ST_SISSUE, ST_SCHECK, ST_TTEST, ST_TCHECK, ST_DONE
   } state_type;

   state_type state_ff;

   logic signed [VALUE_BITS-1:0] store_ff [MAX_ITEMS];
   logic [CW-1:0]                count_ff;
   logic                         overflow_ff;
   logic signed [SW-1:0]         negsum_ff, possum_ff;
   logic signed [VALUE_BITS-1:0] min_ff, max_ff;

   logic [RW-1:0]                r_ff;
   logic [KW-1:0]                k_ff;
   logic signed [SW-1:0]         q_ff;
   logic [WORD_SHIFT-1:0]        b_ff;
   logic [KW-1:0]                vword_ff;
   logic [WORD_SHIFT-1:0]        vbit_ff;
   logic                         bact_ff;
   logic [KW-1:0]                bk_ff;
   logic [WORD_BITS-1:0]         h_ff;

   logic                         v0_ff, v1_ff;
   logic [WORD_SHIFT-1:0]        bit0_ff, bit1_ff;

   logic                         exact_ff;
   logic signed [SW-1:0]         maxd_ff, d_ff, target_ff, remain_ff;
   logic [RW-1:0]                rt_ff;
   logic                         taken_ff;
   logic [MAX_ITEMS-1:0]         mask_ff;

   logic                         rsp_valid_ff;
   logic [MASK_OUT_W-1:0]        rsp_mask_ff;
   logic signed [SUM_OUT_W-1:0]  rsp_sum_ff;
   logic                         rsp_exact_ff;
   logic [COUNT_OUT_W-1:0]       rsp_count_ff;
   logic                         rsp_ovf_ff;

   logic [WORD_BITS-1:0]         rd0_data, rd1_data;
   logic [PW-1:0]                p0, p1;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [WORD_BITS-1:0]         wr_data;

   logic [RW-1:0]                lrow;
   logic [RW-1:0]                esel;
   logic signed [SW-1:0]         elem;
   logic signed [SW-1:0]         ve;
   logic                         rdbit0, rdbit1;
   logic signed [SW-1:0]         negb, posb, maxd_c;
   logic [KW-1:0]                wd;
   logic [WORD_BITS-1:0]         d0, d1, sh, mark;
   logic signed [SW-1:0]         w1;
   logic signed [SW-1:0]         idxv;
   logic [RW-1:0]                prow;

   function automatic logic [PW-1:0] probe(input logic [RW-1:0] row,
                                           input logic signed [SW-1:0] s);
      logic signed [SW-1:0] idx;
      logic                 ok;
      logic [AW-1:0]        a;
      idx = s + $signed(SW'(HALF_SPAN));
      ok  = (idx >= 0) && (idx < $signed(SW'(SPAN)));
      a   = AW'(32'(row) * WORDS) + AW'(idx >>> WORD_SHIFT);
      return {ok, a, idx[WORD_SHIFT-1:0]};
   endfunction

   assign lrow   = RW'(count_ff - CW'(1));
   assign esel   = (state_ff == ST_TCHECK) ? rt_ff : r_ff;
   assign elem   = SW'(store_ff[esel]);
   assign ve     = SW'(req_value);
   assign rdbit0 = v0_ff & rd0_data[bit0_ff];
   assign rdbit1 = v1_ff & rd1_data[bit1_ff];
   assign prow   = r_ff - RW'(1);
   assign idxv   = elem + $signed(SW'(HALF_SPAN));

   assign negb   = (min_ff > 0) ? SW'(min_ff) : negsum_ff;
   assign posb   = (max_ff < 0) ? SW'(max_ff) : possum_ff;
   assign maxd_c = (-negb > posb) ? -negb : posb;

   assign w1 = $signed(SW'(k_ff)) - q_ff - $signed(SW'(1));

   always_comb begin
      p0 = '0;
      p1 = '0;
      unique case (state_ff)
         ST_BSWEEP: begin
            p0 = {(r_ff != '0) && (k_ff != '0),
                  AW'(32'(prow) * WORDS) + AW'(k_ff - KW'(1)), {WORD_SHIFT{1'b0}}};
            p1 = {(r_ff != '0) && (w1 >= 0) && (w1 < $signed(SW'(WORDS))),
                  AW'(32'(prow) * WORDS) + AW'(w1), {WORD_SHIFT{1'b0}}};
         end
         ST_XISSUE: p0 = probe(lrow, '0);
         ST_SISSUE: begin
            p0 = probe(lrow, -d_ff);
            p1 = probe(lrow, d_ff);
         end
         ST_TTEST:  p0 = probe(rt_ff - RW'(1), remain_ff);
         default: begin
            p0 = '0;
            p1 = '0;
         end
      endcase
   end

   assign wd      = bk_ff - KW'(1);
   assign d0      = v0_ff ? rd0_data : '0;
   assign d1      = v1_ff ? rd1_data : '0;
   assign sh      = (d1 << b_ff) | (h_ff >> (7'd64 - {1'b0, b_ff}));
   assign mark    = (wd == vword_ff) ? (64'(1) << vbit_ff) : '0;
   assign wr_en   = bact_ff && (bk_ff != '0);
   assign wr_addr = AW'(32'(r_ff) * WORDS) + AW'(wd);
   assign wr_data = d0 | sh | mark;

   sssnz_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd0_addr (p0[AW+WORD_SHIFT-1:WORD_SHIFT]),
      .rd1_addr (p1[AW+WORD_SHIFT-1:WORD_SHIFT]),
      .rd0_data (rd0_data),
      .rd1_data (rd1_data)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      v0_ff   <= p0[PW-1];
      v1_ff   <= p1[PW-1];
      bit0_ff <= p0[WORD_SHIFT-1:0];
      bit1_ff <= p1[WORD_SHIFT-1:0];
      bk_ff   <= k_ff;
      if (bact_ff) begin
         h_ff <= d1;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bact_ff      <= 1'b0;
      end else begin
         bact_ff <= (state_ff == ST_BSWEEP);
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (count_ff < CW'(MAX_ITEMS)) begin
                     store_ff[count_ff[RW-1:0]] <= req_value;
                     count_ff <= count_ff + CW'(1);
                     if (count_ff == '0) begin
                        negsum_ff <= (ve < 0) ? ve : '0;
                        possum_ff <= (ve < 0) ? '0 : ve;
                        min_ff    <= req_value;
                        max_ff    <= req_value;
                     end else begin
                        if (ve < 0) begin
                           negsum_ff <= negsum_ff + ve;
                        end else begin
                           possum_ff <= possum_ff + ve;
                        end
                        if (req_value < min_ff) begin
                           min_ff <= req_value;
                        end
                        if (req_value > max_ff) begin
                           max_ff <= req_value;
                        end
                     end
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  if (req_last) begin
                     r_ff     <= '0;
                     state_ff <= ST_BROW;
                  end
               end
            end
            ST_BROW: begin
               q_ff     <= elem >>> WORD_SHIFT;
               b_ff     <= elem[WORD_SHIFT-1:0];
               vword_ff <= KW'(idxv >>> WORD_SHIFT);
               vbit_ff  <= idxv[WORD_SHIFT-1:0];
               k_ff     <= '0;
               state_ff <= ST_BSWEEP;
            end
            ST_BSWEEP: begin
               k_ff <= k_ff + KW'(1);
               if (k_ff == KW'(WORDS)) begin
                  state_ff <= ST_BDRAIN;
               end
            end
            ST_BDRAIN: begin
               if (r_ff == lrow) begin
                  rt_ff    <= lrow;
                  taken_ff <= 1'b0;
                  mask_ff  <= '0;
                  state_ff <= ST_XISSUE;
               end else begin
                  r_ff     <= r_ff + RW'(1);
                  state_ff <= ST_BROW;
               end
            end
            ST_XISSUE: begin
               maxd_ff  <= maxd_c;
               d_ff     <= $signed(SW'(1));
               state_ff <= ST_XCHECK;
            end
            ST_XCHECK: begin
               exact_ff <= rdbit0;
               if (rdbit0 || (maxd_ff < 1)) begin
                  target_ff <= '0;
                  remain_ff <= '0;
                  state_ff  <= ST_TTEST;
               end else begin
                  state_ff <= ST_SISSUE;
               end
            end
            ST_SISSUE: state_ff <= ST_SCHECK;
            ST_SCHECK: begin
               if (rdbit0) begin
                  target_ff <= -d_ff;
                  remain_ff <= -d_ff;
                  state_ff  <= ST_TTEST;
               end else if (rdbit1) begin
                  target_ff <= d_ff;
                  remain_ff <= d_ff;
                  state_ff  <= ST_TTEST;
               end else if (d_ff == maxd_ff) begin
                  target_ff <= '0;
                  remain_ff <= '0;
                  state_ff  <= ST_TTEST;
               end else begin
                  d_ff     <= d_ff + $signed(SW'(1));
                  state_ff <= ST_SISSUE;
               end
            end
            ST_TTEST: begin
               if ((rt_ff == '0) || (taken_ff && (remain_ff == '0))) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_TCHECK;
               end
            end
            ST_TCHECK: begin
               if (!rdbit0) begin
                  mask_ff[rt_ff] <= 1'b1;
                  remain_ff      <= remain_ff - elem;
                  taken_ff       <= 1'b1;
               end
               rt_ff    <= rt_ff - RW'(1);
               state_ff <= ST_TTEST;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mask_ff  <= MASK_OUT_W'(mask_ff |
                                  MAX_ITEMS'(!taken_ff || (remain_ff != '0)));
                  rsp_sum_ff   <= SUM_OUT_W'(target_ff);
                  rsp_exact_ff <= exact_ff;
                  rsp_count_ff <= COUNT_OUT_W'(count_ff);
                  rsp_ovf_ff   <= overflow_ff;
                  count_ff     <= '0;
                  overflow_ff  <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_subset_mask   = rsp_mask_ff;
   assign rsp_subset_sum    = rsp_sum_ff;
   assign rsp_exact_zero    = rsp_exact_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_overflowed    = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("element count past capacity");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0) || (MAX_ITEMS >= 32))
      else $error("result with empty set");

   a_exact_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exact_ff) |-> (rsp_sum_ff == '0))
      else $error("exact zero with nonzero sum");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) |=>
      (count_ff == '0) && !overflow_ff && rsp_valid_ff)
      else $error("result load did not clear set");
`endif

endmodule
